// File: src/sorted_list_insert_delete_defines.svh
// Assertion macros for the sorted list block.
// Used by sorted_list_insert_delete.sv; expects clk and rst in scope.
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define SLID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list check failed");

// Next-cycle implication, gated off during reset.
`define SLID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list check failed");

`endif

// File: src/slid_pkg.sv
// Shared types and constants for the sorted list block.
// No dependencies; imported by slid_cell and sorted_list_insert_delete.
package slid_pkg;

  localparam int SLID_DEPTH = 16;
  localparam int VAL_W      = 32;
  localparam int CNT_OUT_W  = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Operation token that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic                    valid;
    cmd_t                    cmd;
    logic                    drop;   // insert into full list: touch nothing
    logic                    hit;    // insert placed / delete matched
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] carry;  // value pushed right by an insert
  } tok_t;

endpackage

// File: src/slid_cell.sv
// One storage cell of the sorted list chain: holds one entry and one token stage.
// Depends on slid_pkg.
module slid_cell
  import slid_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    occ,
  input  tok_t                    tin,
  input  logic                    right_pull,
  input  logic signed [VAL_W-1:0] right_entry,
  output tok_t                    tout,
  output logic                    pull,
  output logic signed [VAL_W-1:0] entry_out
);

  logic signed [VAL_W-1:0] entry;
  logic signed [VAL_W-1:0] entry_next;
  tok_t                    tok_next;

  always_comb begin
    tok_next   = tin;
    entry_next = entry;
    if (tin.valid && !tin.drop) begin
      case (tin.cmd)
        CMD_INSERT: begin
          if (tin.hit) begin
            // shift right: take the carried word, pass ours on
            entry_next     = tin.carry;
            tok_next.carry = entry;
          end else if (!occ || !(entry < tin.value)) begin
            entry_next     = tin.value;
            tok_next.carry = entry;
            tok_next.hit   = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (!tin.hit && occ && (entry == tin.value)) begin
            tok_next.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // close the gap left by a delete: take the right neighbor's word
    if (right_pull) begin
      entry_next = right_entry;
    end
  end

  assign pull      = tin.valid && !tin.drop && (tin.cmd == CMD_DELETE) && tin.hit;
  assign entry_out = entry;

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      tout <= '0;
    end else begin
      tout <= tok_next;
    end
  end

endmodule

// File: src/sorted_list_insert_delete.sv
// Sorted list of signed 32-bit values with insert and delete.
// Input channel: in_valid / in_stall with cmd (0 insert, 1 delete) and value.
// Output channel: out_valid / out_stall with status and entry_count.
// An insert goes ahead of equal values; a delete removes the first equal one.
// Each accepted word yields exactly one result word.
// An accepted word is registered as the operation token, which walks the chain
// of DEPTH cells one cell per cycle into a holding stage and then into the
// output register. One word is in the chain at a time: in_stall stays high until the
// result has moved into the output register.
// A stalled result holds in the output register; the next input word can be
// accepted while it waits, and its own result waits in a holding stage.
// Reset (rst, synchronous, active high) empties the list and clears both
// channels; no clearing pass is needed. Depends on slid_pkg, slid_cell and
// sorted_list_insert_delete_defines.svh.
`include "sorted_list_insert_delete_defines.svh"

module sorted_list_insert_delete
  import slid_pkg::*;
#(
  parameter int DEPTH = SLID_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic signed [VAL_W-1:0]     value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [CNT_OUT_W-1:0]        entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  tok_t          head;
  tok_t          head_next;
  logic          in_acc;

  tok_t                    tin_v   [DEPTH];
  tok_t                    tout_v  [DEPTH];
  logic                    pull_v  [DEPTH];
  logic                    rpull_v [DEPTH];
  logic signed [VAL_W-1:0] ent_v   [DEPTH];
  logic signed [VAL_W-1:0] rent_v  [DEPTH];
  logic [DEPTH-1:0]        occ;

  tok_t    last;
  logic    tail_valid;
  status_t tail_status;
  status_t st_next;
  logic    move;

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    head_next       = '0;
    head_next.valid = in_acc;
    head_next.cmd   = cmd_t'(cmd);
    head_next.value = value;
    head_next.hit   = 1'b0;
    head_next.drop  = (cmd_t'(cmd) == CMD_INSERT) && (count == CW'(DEPTH));
  end

  generate
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      assign occ[k] = (CW'(k) < count);
      if (k == 0) begin : g_first
        assign tin_v[k] = head;
      end else begin : g_mid
        assign tin_v[k] = tout_v[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
        assign rpull_v[k] = 1'b0;
        assign rent_v[k]  = '0;
      end else begin : g_inner
        assign rpull_v[k] = pull_v[k+1];
        assign rent_v[k]  = ent_v[k+1];
      end
      slid_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .occ         (occ[k]),
        .tin         (tin_v[k]),
        .right_pull  (rpull_v[k]),
        .right_entry (rent_v[k]),
        .tout        (tout_v[k]),
        .pull        (pull_v[k]),
        .entry_out   (ent_v[k])
      );
    end
  endgenerate

  assign last = tout_v[DEPTH-1];
  assign move = tail_valid && (!out_valid || !out_stall);

  always_comb begin
    count_next = count;
    st_next    = ST_NOT_FOUND;
    if (last.drop) begin
      st_next = ST_FULL;
    end else if (last.cmd == CMD_INSERT) begin
      st_next    = ST_INSERTED;
      count_next = count + CW'(1);
    end else if (last.hit) begin
      st_next    = ST_DELETED;
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      busy        <= 1'b0;
      count       <= '0;
      tail_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      head <= head_next;
      if (in_acc) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      // token leaves the chain: commit the count, hold the result
      if (last.valid) begin
        count       <= count_next;
        tail_valid  <= 1'b1;
        tail_status <= st_next;
      end else if (move) begin
        tail_valid <= 1'b0;
      end
      if (move) begin
        out_valid   <= 1'b1;
        status      <= tail_status;
        entry_count <= CNT_OUT_W'(count);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SLID_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `SLID_ASSERT_NOW(a_idle_empty, !busy, !tail_valid && !head.valid && !last.valid)
  `SLID_ASSERT_NEXT(a_accept_busy, in_acc, busy && head.valid)
  `SLID_ASSERT_NEXT(a_insert_grows, last.valid && !last.drop && (last.cmd == CMD_INSERT),
                    count == $past(count) + CW'(1))

endmodule

// File: test/testbench.sv
// Self-checking bench for sorted_list_insert_delete: random and directed insert
// and delete words, a tracking list that predicts each status and count word.
// Depends on slid_pkg and the sorted_list_insert_delete RTL.
`timescale 1ns / 100ps

module testbench;
  import slid_pkg::*;

  typedef struct packed {
    cmd_t                    op;
    logic signed [VAL_W-1:0] val;
  } list_word_t;

  typedef struct packed {
    status_t              st;
    logic [CNT_OUT_W-1:0] cnt;
  } list_result_t;

  localparam int BURST_LEN = 42;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic signed [VAL_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [CNT_OUT_W-1:0] entry_count;

  list_word_t pending_words[$];
  list_result_t expected_results[$];

  // Tracking copy of the list contents
  logic signed [VAL_W-1:0] shadow_list [SLID_DEPTH];
  int shadow_count = 0;

  logic signed [VAL_W-1:0] value_pool [8];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  bit word_taken = 1'b0;
  bit failed = 1'b0;

  sorted_list_insert_delete uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic list_result_t list_apply(cmd_t op, logic signed [VAL_W-1:0] v);
    int pos;
    int i;
    list_result_t r;
    pos = 0;
    if (op == CMD_INSERT) begin
      if (shadow_count >= SLID_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        // land ahead of equal values
        while (pos < shadow_count && shadow_list[pos] < v) pos++;
        for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
        shadow_list[pos] = v;
        shadow_count++;
        r.st = ST_INSERTED;
      end
    end else begin
      while (pos < shadow_count && shadow_list[pos] != v) pos++;
      if (pos >= shadow_count) begin
        r.st = ST_NOT_FOUND;
      end else begin
        for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
        shadow_count--;
        r.st = ST_DELETED;
      end
    end
    r.cnt = shadow_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  // Check result words first, then predict the input word taken at this edge
  always @(posedge clk) begin : scoreboard
    list_result_t want;
    word_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: status %0d, entry_count %0d",
                 status, entry_count);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st) begin
            $error("status mismatch: expected %0d, got %0d", want.st, status);
            failed = 1'b1;
          end
          if (entry_count !== want.cnt) begin
            $error("entry_count mismatch: expected %0d, got %0d", want.cnt, entry_count);
            failed = 1'b1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        word_taken = 1'b1;
        expected_results.push_back(list_apply(cmd_t'(cmd), value));
      end
    end
  end

  // Hold the word until taken, then advance or idle
  always @(negedge clk) begin : driver
    list_word_t nxt;
    if (!rst && (!in_valid || word_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_words.pop_front();
        in_valid <= 1'b1;
        cmd <= nxt.op;
        value <= nxt.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_done != hold_asked) begin
      hold_done = hold_asked;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_word(cmd_t op, logic signed [VAL_W-1:0] v);
    list_word_t w;
    w.op = op;
    w.val = v;
    pending_words.push_back(w);
  endtask

  task automatic wait_sent();
    do begin
      @(posedge clk);
      #1;
    end while (pending_words.size() != 0 || in_valid);
  endtask

  task automatic wait_all_done();
    do begin
      @(posedge clk);
      #1;
    end while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return value_pool[$urandom_range(7)];
    if (r < 58) return 32'sh7FFFFFFF;
    if (r < 61) return 32'sh80000000;
    if (r < 64) return 0;
    if (r < 67) return -1;
    return $urandom;
  endfunction

  task automatic run_phase(int send_pct, int recv_pct, int bursts, bit with_hold);
    int b;
    int k;
    int ins_pct;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (b = 0; b < bursts; b++) begin
      // half wide values, half a narrow band so duplicates and hits are common
      for (k = 0; k < 8; k++) begin
        if (k < 4) value_pool[k] = $urandom;
        else value_pool[k] = $urandom_range(6) - 3;
      end
      // alternate filling and draining bursts to sweep the count
      ins_pct = (b % 2 == 0) ? 80 : 25;
      for (k = 0; k < BURST_LEN; k++) begin
        push_word(($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE, pick_value());
      end
      if (with_hold && b == 2) begin
        hold_asked = hold_asked + 1;
        wait_sent();
        // sender pause until every result is back
        wait_all_done();
      end else begin
        wait_sent();
      end
    end
    wait_all_done();
  endtask

  initial begin : stimulus
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_word(CMD_DELETE, 0);
    push_word(CMD_INSERT, 32'sh7FFFFFFF);
    push_word(CMD_INSERT, 32'sh80000000);
    push_word(CMD_INSERT, 0);
    push_word(CMD_INSERT, -1);
    push_word(CMD_INSERT, 5);
    push_word(CMD_INSERT, 5);
    for (k = 0; k < 10; k++) push_word(CMD_INSERT, k * 1000 - 4000);
    push_word(CMD_INSERT, 5);
    push_word(CMD_INSERT, 32'sh7FFFFFFF);
    push_word(CMD_DELETE, 5);
    push_word(CMD_DELETE, 5);
    push_word(CMD_DELETE, 5);
    push_word(CMD_DELETE, 32'sh7FFFFFFF);
    push_word(CMD_DELETE, 32'sh80000000);
    push_word(CMD_DELETE, 32'sh55AA55AA);
    wait_all_done();

    run_phase(0, 0, 8, 1'b0);
    run_phase(63, 0, 8, 1'b0);
    run_phase(0, 63, 8, 1'b0);
    run_phase(21, 21, 8, 1'b0);
    run_phase(21, 21, 8, 1'b1);

    wait_all_done();
    repeat (2 * (SLID_DEPTH + 2)) @(posedge clk);
    #1;
    if (!failed && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
